// ===== design/ctlp_pkg.sv =====
// ----------------------------------------------------------------------------
// ctlp_pkg
// Shared types, token numbers and helpers for the text CAN log line parser.
// ----------------------------------------------------------------------------
package ctlp_pkg;

  localparam int MAX_DATA_BYTES = 8;
  localparam int DATA_IDX_W     = $clog2(MAX_DATA_BYTES);

  localparam logic [3:0] TOK_TIME  = 4'd0;
  localparam logic [3:0] TOK_ID    = 4'd2;
  localparam logic [3:0] TOK_TYPE  = 4'd3;
  localparam logic [3:0] TOK_BUS   = 4'd4;
  localparam logic [3:0] TOK_LEN   = 4'd5;
  localparam logic [3:0] TOK_DATA0 = 4'd6;
  localparam logic [3:0] TOK_LAST  = 4'd15;

  localparam logic [7:0] CHAR_NL  = 8'h0A;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_S   = 8'h53;
  localparam logic [7:0] CHAR_X   = 8'h58;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_TYPE = 2'd1,
    STATUS_BAD_LEN  = 2'd2
  } ctlp_status_t;

  typedef enum logic [1:0] {
    TYPE_NONE  = 2'd0,
    TYPE_S     = 2'd1,
    TYPE_X     = 2'd2,
    TYPE_OTHER = 2'd3
  } ctlp_type_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DEC  = 2'd1,
    KIND_HEX  = 2'd2
  } ctlp_kind_t;

  // classified character as it travels through the queue
  typedef struct packed {
    logic       nl;
    logic       sep;
    logic       is_s;
    logic       is_x;
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] digit;
  } ctlp_item_t;

  typedef struct packed {
    ctlp_status_t status;
    logic [31:0]  time_us;
    logic [28:0]  can_id;
    logic         is_extended;
    logic [3:0]   bus_index;
    logic [3:0]   data_length;
    logic [63:0]  payload;
  } ctlp_frame_t;

  function automatic ctlp_kind_t token_kind(input logic [3:0] t);
    ctlp_kind_t k;
    k = KIND_NONE;
    if (t == TOK_TIME || t == TOK_BUS || t == TOK_LEN) begin
      k = KIND_DEC;
    end else if (t == TOK_ID ||
                 (t >= TOK_DATA0 && t < TOK_DATA0 + 4'(MAX_DATA_BYTES))) begin
      k = KIND_HEX;
    end
    return k;
  endfunction

endpackage

// ===== design/ctlp_front.sv =====
// ----------------------------------------------------------------------------
// ctlp_front
// Accepts characters, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ctlp_front
  import ctlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       item_valid,
  input  logic       item_ready,
  output ctlp_item_t item
);

  ctlp_item_t cls;
  ctlp_item_t queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  always_comb begin
    cls        = '0;
    cls.nl     = (rx_byte == CHAR_NL);
    cls.sep    = (rx_byte == CHAR_SP) || (rx_byte == CHAR_TAB);
    cls.is_s   = (rx_byte == CHAR_S);
    cls.is_x   = (rx_byte == CHAR_X);
    if (rx_byte inside {[8'h30:8'h39]}) begin
      cls.dec_ok = 1'b1;
      cls.hex_ok = 1'b1;
      cls.digit  = 4'(rx_byte - 8'h30);
    end else if (rx_byte inside {[8'h61:8'h66]}) begin
      cls.hex_ok = 1'b1;
      cls.digit  = 4'(rx_byte - 8'h57);
    end else if (rx_byte inside {[8'h41:8'h46]}) begin
      cls.hex_ok = 1'b1;
      cls.digit  = 4'(rx_byte - 8'h37);
    end
  end

  assign rx_ready   = (count != 2'd2);
  assign push       = rx_valid && rx_ready;
  assign item_valid = (count != 2'd0);
  assign pop        = item_valid && item_ready;
  assign item       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/ctlp_back.sv =====
// ----------------------------------------------------------------------------
// ctlp_back
// Token state machine: collects fields and emits one frame per line.
// ----------------------------------------------------------------------------
module ctlp_back
  import ctlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  ctlp_item_t  item,
  output logic        frame_valid,
  input  logic        frame_ready,
  output ctlp_frame_t frame
);

  logic [3:0]  token_number, token_number_next;
  logic        in_token, in_token_next;
  logic        token_stopped, token_stopped_next;
  logic [31:0] field_accum, field_accum_next;
  logic [31:0] stamp_reg, stamp_next;
  logic [28:0] ident_reg, ident_next;
  ctlp_type_t  type_flags, type_next;
  logic [3:0]  bus_reg, bus_next;
  logic [3:0]  length_reg, length_next;
  logic [7:0]  data_store [MAX_DATA_BYTES];
  logic [7:0]  data_next [MAX_DATA_BYTES];
  logic        frame_valid_next;

  // values after closing the open token
  logic [31:0] stamp_c;
  logic [28:0] ident_c;
  logic [3:0]  bus_c;
  logic [3:0]  length_c;
  logic [7:0]  data_c [MAX_DATA_BYTES];
  logic        commit;
  logic        pop;
  ctlp_frame_t result;
  ctlp_kind_t  kind;
  logic [31:0] acc_base;
  logic        digit_ok;
  logic [DATA_IDX_W-1:0] data_idx;

  assign item_ready = !item.nl || !frame_valid || frame_ready;
  assign pop        = item_valid && item_ready;
  assign commit     = in_token && (item.nl || item.sep);
  assign kind       = token_kind(token_number);
  assign data_idx   = DATA_IDX_W'(token_number - TOK_DATA0);

  always_comb begin
    stamp_c  = stamp_reg;
    ident_c  = ident_reg;
    bus_c    = bus_reg;
    length_c = length_reg;
    data_c   = data_store;
    if (commit) begin
      case (token_number)
        TOK_TIME: stamp_c = field_accum;
        TOK_ID:   ident_c = field_accum[28:0];
        TOK_BUS:  bus_c = field_accum[3:0];
        TOK_LEN:  length_c = (field_accum > 32'd15) ? 4'd15 : field_accum[3:0];
        default: begin
          if (token_number >= TOK_DATA0 &&
              token_number < TOK_DATA0 + 4'(MAX_DATA_BYTES)) begin
            data_c[data_idx] = field_accum[7:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    result             = '0;
    result.time_us     = stamp_c;
    result.can_id      = ident_c;
    result.is_extended = (type_flags == TYPE_X);
    result.bus_index   = bus_c;
    result.data_length = length_c;
    if (type_flags != TYPE_S && type_flags != TYPE_X) begin
      result.status = STATUS_BAD_TYPE;
    end else if (length_c > 4'(MAX_DATA_BYTES)) begin
      result.status = STATUS_BAD_LEN;
    end else begin
      result.status = STATUS_OK;
    end
    for (int k = 0; k < MAX_DATA_BYTES; k++) begin
      if (length_c <= 4'(MAX_DATA_BYTES) && 4'(k) < length_c) begin
        result.payload[8*k +: 8] = data_c[k];
      end
    end
  end

  always_comb begin
    acc_base = in_token ? field_accum : 32'd0;
    case (kind)
      KIND_DEC: digit_ok = item.dec_ok;
      KIND_HEX: digit_ok = item.hex_ok;
      default:  digit_ok = 1'b0;
    endcase
  end

  always_comb begin
    token_number_next  = token_number;
    in_token_next      = in_token;
    token_stopped_next = token_stopped;
    field_accum_next   = field_accum;
    stamp_next         = stamp_reg;
    ident_next         = ident_reg;
    type_next          = type_flags;
    bus_next           = bus_reg;
    length_next        = length_reg;
    data_next          = data_store;
    frame_valid_next   = frame_valid && !frame_ready;
    if (pop) begin
      if (item.nl) begin
        frame_valid_next   = 1'b1;
        token_number_next  = TOK_TIME;
        in_token_next      = 1'b0;
        token_stopped_next = 1'b0;
        field_accum_next   = '0;
        stamp_next         = '0;
        ident_next         = '0;
        type_next          = TYPE_NONE;
        bus_next           = '0;
        length_next        = '0;
        for (int k = 0; k < MAX_DATA_BYTES; k++) begin
          data_next[k] = '0;
        end
      end else if (item.sep) begin
        stamp_next  = stamp_c;
        ident_next  = ident_c;
        bus_next    = bus_c;
        length_next = length_c;
        data_next   = data_c;
        if (in_token) begin
          in_token_next      = 1'b0;
          token_stopped_next = 1'b0;
          if (token_number < TOK_LAST) begin
            token_number_next = token_number + 4'd1;
          end
        end
      end else begin
        in_token_next = 1'b1;
        if (!in_token) begin
          token_stopped_next = 1'b0;
          field_accum_next   = '0;
          if (token_number == TOK_TYPE) begin
            type_next = item.is_s ? TYPE_S : (item.is_x ? TYPE_X : TYPE_OTHER);
          end
        end
        if (!in_token || !token_stopped) begin
          if (!digit_ok) begin
            token_stopped_next = 1'b1;
          end else if (kind == KIND_DEC) begin
            field_accum_next = (acc_base << 3) + (acc_base << 1) + 32'(item.digit);
          end else begin
            field_accum_next = {acc_base[27:0], item.digit};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_number  <= TOK_TIME;
      in_token      <= 1'b0;
      token_stopped <= 1'b0;
      field_accum   <= '0;
      stamp_reg     <= '0;
      ident_reg     <= '0;
      type_flags    <= TYPE_NONE;
      bus_reg       <= '0;
      length_reg    <= '0;
      for (int k = 0; k < MAX_DATA_BYTES; k++) begin
        data_store[k] <= '0;
      end
      frame_valid   <= 1'b0;
    end else begin
      token_number  <= token_number_next;
      in_token      <= in_token_next;
      token_stopped <= token_stopped_next;
      field_accum   <= field_accum_next;
      stamp_reg     <= stamp_next;
      ident_reg     <= ident_next;
      type_flags    <= type_next;
      bus_reg       <= bus_next;
      length_reg    <= length_next;
      data_store    <= data_next;
      frame_valid   <= frame_valid_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (pop && item.nl) begin
      frame <= result;
    end
  end

endmodule

// ===== design/can_text_line_parser.sv =====
// ----------------------------------------------------------------------------
// can_text_line_parser
// Parses ASCII CAN log lines into decoded frames, one character per request.
// ----------------------------------------------------------------------------
// Takes one character per cycle while the queue has room. Each character is
// classified on entry and waits in a two-entry queue; the token logic behind
// it handles one queued character per cycle, except a newline held back by a
// pending frame. A newline produces one frame: it passes through the queue
// and is then written into the output register when the token logic takes it.
// The input keeps flowing while a frame waits; only a second newline waits
// until the pending frame is taken, and the input stops once the queue fills.
module can_text_line_parser
  import ctlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        frame_valid,
  input  logic        frame_ready,
  output logic [1:0]  frame_status,
  output logic [31:0] time_us,
  output logic [28:0] can_id,
  output logic        is_extended,
  output logic [3:0]  bus_index,
  output logic [3:0]  data_length,
  output logic [63:0] payload
);

  logic        item_valid;
  logic        item_ready;
  ctlp_item_t  item;
  ctlp_frame_t frame;

  ctlp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  ctlp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  assign frame_status = frame.status;
  assign time_us      = frame.time_us;
  assign can_id       = frame.can_id;
  assign is_extended  = frame.is_extended;
  assign bus_index    = frame.bus_index;
  assign data_length  = frame.data_length;
  assign payload      = frame.payload;

`ifndef SYNTH
  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_status == STATUS_OK |-> data_length <= 4'(MAX_DATA_BYTES))
    else $error("ok frame with length above limit");

  a_ext_type: assert property (@(posedge clk) disable iff (rst)
    frame_valid && is_extended |-> frame_status != STATUS_BAD_TYPE)
    else $error("extended frame flagged as bad type");

  a_len_payload: assert property (@(posedge clk) disable iff (rst)
    frame_valid && data_length > 4'(MAX_DATA_BYTES) |-> payload == 64'd0)
    else $error("payload not cleared for oversize length");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> frame_status == STATUS_OK || frame_status == STATUS_BAD_TYPE ||
                    frame_status == STATUS_BAD_LEN)
    else $error("unknown frame status");
`endif

endmodule
